// File: design/trial_division_prime_table_macros.svh
// Assertion macros for the prime table block.
// Used by the checker module only.
`ifndef TRIAL_DIVISION_PRIME_TABLE_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TABLE_MACROS_SVH
// implication checked on every edge outside reset
`define TDPT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdpt check failed");
// implication with the consequent checked in the next cycle
`define TDPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdpt check failed");
`endif

// File: design/tdpt_pkg.sv
// Shared constants and types for the prime table block.
// No dependencies.
`timescale 1ns / 1ps
package tdpt_pkg;
	localparam int TableDepth = 4096;
	localparam int ValueWidth = 32;
	localparam int AddrWidth  = $clog2(TableDepth);
	localparam int CountWidth = AddrWidth + 1;
	localparam int DivCntWidth = $clog2(ValueWidth + 1);

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [CountWidth-1:0] count_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;       // capture candidate, set bound
		logic read_req;   // read table at current index
		logic div_start;  // begin division by read prime
		logic div_step;   // one quotient bit
		logic bound_upd;  // shrink bound, next index
		logic finish;     // compute verdict and update table
	} cmd_t;

	typedef struct packed {
		logic below_two;  // candidate below two
		logic idx_end;    // index reached prime count
		logic at_bound;   // prime at or above bound
		logic div_done;
		logic rem_zero;
	} stat_t;
endpackage

// File: design/tdpt_ram.sv
// Generic single port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tdpt_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: design/tdpt_datapath.sv
// Datapath: candidate, bound, restoring divider, table and counters.
// Depends on tdpt_pkg and tdpt_ram.
`timescale 1ns / 1ps
module tdpt_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tdpt_pkg::value_t        cand_in,
	input  tdpt_pkg::cmd_t          cmd,
	output tdpt_pkg::stat_t         stat,
	output logic                    prime_o,
	output tdpt_pkg::count_t        count_o,
	output logic                    full_o
);
	import tdpt_pkg::*;

	value_t                 cand_q, bound_q, div_q, quo_q, rem_q;
	logic [ValueWidth:0]    rem_try;
	logic [DivCntWidth-1:0] bit_q;
	count_t                 idx_q, count_q;
	logic                   full_q, prime_q;
	value_t                 rd_data;
	logic                   we;
	logic [AddrWidth-1:0]   addr;
	logic [ValueWidth:0]    nb;
	logic                   verdict;

	assign verdict = !stat.below_two && (stat.idx_end || stat.at_bound || !stat.rem_zero);
	assign we   = cmd.finish && verdict && (count_q != count_t'(TableDepth));
	assign addr = we ? count_q[AddrWidth-1:0] : idx_q[AddrWidth-1:0];

	tdpt_ram #(.Width(ValueWidth), .Depth(TableDepth)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(cand_q), .rdata(rd_data)
	);

	// shift in next dividend bit, trial subtract
	assign rem_try = {rem_q, quo_q[ValueWidth-1]} - {1'b0, div_q};
	assign nb = {1'b0, quo_q} + {1'b0, div_q} - (ValueWidth+1)'(1);

	assign stat.below_two = cand_q < value_t'(2);
	assign stat.idx_end   = idx_q == count_q;
	assign stat.at_bound  = rd_data >= bound_q;
	assign stat.div_done  = bit_q == '0;
	assign stat.rem_zero  = rem_q == '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_q  <= cand_in;
			bound_q <= (cand_in >> 1) + value_t'(1);
		end
		if (cmd.div_start) begin
			div_q <= rd_data;
			quo_q <= cand_q;
			rem_q <= '0;
			bit_q <= DivCntWidth'(ValueWidth);
		end else if (cmd.div_step) begin
			if (!rem_try[ValueWidth]) begin
				rem_q <= rem_try[ValueWidth-1:0];
				quo_q <= {quo_q[ValueWidth-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[ValueWidth-2:0], quo_q[ValueWidth-1]};
				quo_q <= {quo_q[ValueWidth-2:0], 1'b0};
			end
			bit_q <= bit_q - DivCntWidth'(1);
		end
		if (cmd.bound_upd && nb < {1'b0, bound_q}) begin
			bound_q <= nb[ValueWidth-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
			full_q  <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.bound_upd) begin
				idx_q <= idx_q + count_t'(1);
			end
			if (cmd.finish) begin
				prime_q <= verdict;
				if (we) begin
					count_q <= count_q + count_t'(1);
				end else if (verdict) begin
					full_q <= 1'b1;
				end
			end
		end
	end

	assign prime_o = prime_q;
	assign count_o = count_q;
	assign full_o  = full_q;
endmodule

// File: design/tdpt_ctrl.sv
// Controller state machine sequencing the trial division walk.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps
module tdpt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  tdpt_pkg::stat_t stat,
	output tdpt_pkg::cmd_t  cmd
);
	import tdpt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_READ;
			ST_READ:   state_d = (stat.below_two || stat.idx_end) ? ST_UPDATE : ST_CHECK;
			ST_CHECK:  state_d = stat.at_bound ? ST_UPDATE : ST_DIV;
			ST_DIV:    if (stat.div_done) state_d = stat.rem_zero ? ST_UPDATE : ST_READ;
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// at ST_DIV exit with nonzero remainder the bound is updated
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_READ:  cmd.read_req = 1'b1;
			ST_CHECK: cmd.div_start = !stat.at_bound;
			ST_DIV: begin
				cmd.div_step  = !stat.div_done;
				cmd.bound_upd = stat.div_done && !stat.rem_zero;
			end
			ST_UPDATE: cmd.finish = 1'b1;
			ST_OUT:    out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// File: design/trial_division_prime_table.sv
// Prime table by trial division: top level joining controller and datapath.
// Depends on tdpt_pkg, tdpt_ctrl, tdpt_datapath.
//
// Input channel: candidate with valid/ready, increasing values from 2.
// Output channel: is_prime, primes_stored, table_full with valid/ready.
// One result word per candidate. One candidate is in flight at a time.
// After a candidate is accepted, one below two or an empty walk goes
// straight to the verdict; otherwise each stored prime is read from the
// table, compared with the bound and, if below it, tried in the 32-step
// restoring divider. The walk ends on a dividing prime, on a prime at the
// bound or when the stored primes run out. The result word is then
// presented, and the block returns to idle before it accepts the next one.
// The result is held in registers until the receiver takes it; a stalled
// receiver holds the block, which accepts nothing meanwhile.
// Reset clears the prime count and full flag; the table memory needs no
// clearing since only written entries are ever read.
`timescale 1ns / 1ps
module trial_division_prime_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [31:0]             candidate,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    is_prime,
	output logic [12:0]             primes_stored,
	output logic                    table_full
);
	import tdpt_pkg::*;

	cmd_t   cmd;
	stat_t  stat;
	count_t count;

	tdpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	tdpt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cand_in(candidate[ValueWidth-1:0]),
		.cmd(cmd), .stat(stat), .prime_o(is_prime), .count_o(count),
		.full_o(table_full)
	);

	assign primes_stored = 13'(count);
endmodule

// File: design/tdpt_checker.sv
// Port level checks for the prime table block, bound to the top level.
// Depends on trial_division_prime_table_macros.svh.
`timescale 1ns / 1ps
`include "trial_division_prime_table_macros.svh"
module tdpt_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_prime,
	input logic [12:0] primes_stored,
	input logic        table_full
);
	// one word in flight: never ready while a result is pending
	`TDPT_ASSERT_IMPL(a_excl, out_valid, !in_ready)
	// result words hold while stalled
	`TDPT_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(is_prime) && $stable(primes_stored))
	// full flag is sticky
	`TDPT_ASSERT_NEXT(a_full, table_full, table_full)
	// composites never grow the table
	`TDPT_ASSERT_IMPL(a_comp, out_valid && !is_prime, $stable(primes_stored) || !$past(out_valid))
endmodule

bind trial_division_prime_table tdpt_port_checks u_tdpt_port_checks (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .is_prime(is_prime),
	.primes_stored(primes_stored), .table_full(table_full)
);

// File: dv/tdpt_checker.sv
// Checker for the prime table block: watches both channels and predicts each result word.
// It keeps its own prime list, then compares the words in order.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps
module tdpt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] candidate,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        is_prime,
	input  logic [12:0] primes_stored,
	input  logic        table_full,
	output int          fail_count,
	output int          pending
);
	import tdpt_pkg::*;

	typedef struct {
		logic        prime;
		logic [12:0] stored;
		logic        full;
	} verdict_t;

	verdict_t   verdict_q[$];
	value_t     found_primes[TableDepth];
	int         found_count;
	logic       overflowed;

	// walk the found primes, shrinking the search bound after each miss
	function automatic logic trial_divide(input value_t n);
		logic [63:0] lim;
		logic [63:0] div;
		logic [63:0] shrunk;
		if (n < 2)
			return 1'b0;
		lim = (64'(n) >> 1) + 1;
		for (int i = 0; i < found_count; i++) begin
			div = 64'(found_primes[i]);
			if (div >= lim)
				return 1'b1;
			if (64'(n) % div == 0)
				return 1'b0;
			shrunk = 64'(n) / div + div - 1;
			if (shrunk < lim)
				lim = shrunk;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t v;
		verdict_t got;
		if (!arst_n) begin
			verdict_q.delete();
			found_count = 0;
			overflowed  = 1'b0;
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (out_valid && out_ready) begin
				got.prime  = is_prime;
				got.stored = primes_stored;
				got.full   = table_full;
				if (verdict_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word: prime=%0b stored=%0d full=%0b",
							got.prime, got.stored, got.full);
				end else begin
					v = verdict_q.pop_front();
					if (got.prime !== v.prime || got.stored !== v.stored
							|| got.full !== v.full) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp prime=%0b stored=%0d full=%0b,",
								" got prime=%0b stored=%0d full=%0b"},
								v.prime, v.stored, v.full, got.prime, got.stored, got.full);
					end
				end
			end
			if (in_valid && in_ready) begin
				v.prime = trial_divide(candidate);
				if (v.prime) begin
					if (found_count >= TableDepth)
						overflowed = 1'b1;
					else begin
						found_primes[found_count] = candidate;
						found_count++;
					end
				end
				v.stored = 13'(found_count);
				v.full   = overflowed;
				verdict_q.push_back(v);
			end
			pending = verdict_q.size();
		end
	end
endmodule

// File: dv/tb.sv
// Testbench top for the prime table block: clock, reset, stimulus and verdict.
// Depends on trial_division_prime_table and tdpt_checker.
`timescale 1ns / 1ps
module tb;
	localparam int StallLimit = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] candidate = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_prime;
	logic [12:0] primes_stored;
	logic        table_full;
	int          fail_count;
	int          pending;
	int          quiet_cycles = 0;
	bit          send_gaps = 1'b1;
	bit          take_gaps = 1'b1;

	always #1 clk = ~clk;

	trial_division_prime_table u_dut (.*);

	tdpt_checker u_chk (.*);

	// stall watchdog: cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls, switched off now and then
	initial begin
		int wait_n;
		@(posedge arst_n);
		forever begin
			wait_n = take_gaps ? $urandom_range(0, 13) : 0;
			if (wait_n > 0) begin
				out_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_word(input logic [31:0] value);
		int gap;
		gap = send_gaps ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		candidate <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	initial begin
		logic [31:0] next_n;
		int          roll;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, one, the first primes and composites, then wide values
		for (int n = 0; n <= 20; n++)
			send_word(32'(n));
		send_word(32'hFFFF_FFFF);
		send_word(32'h8000_0000);
		send_word(32'hFFFF_FFFE);
		send_word(32'h7FFF_FFFF);

		// let the block drain completely once before the random part
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		next_n = 21;
		for (int i = 0; i < 265; i++) begin
			if (i % 40 == 0) begin
				send_gaps = ($urandom_range(0, 2) != 0);
				take_gaps = ($urandom_range(0, 2) != 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 82) begin
				send_word(next_n);
				next_n = next_n + $urandom_range(1, 3);
			end else if (roll < 90) begin
				send_word($urandom());
			end else if (roll < 94) begin
				send_word(32'($urandom_range(0, 1)));
			end else begin
				// repeat or step back among earlier values
				send_word(next_n - $urandom_range(1, 20));
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// File: sim.f
+incdir+design
design/tdpt_pkg.sv
design/tdpt_ram.sv
design/tdpt_datapath.sv
design/tdpt_ctrl.sv
design/trial_division_prime_table.sv
design/tdpt_checker.sv
dv/tdpt_checker.sv
dv/tb.sv
